@@ src/sfpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_pkg
// Shared types and constants of the framed packet receiver.
// ----------------------------------------------------------------------------
package sfpr_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd250;
  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECORD_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd2;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam int unsigned OUT_DATA_W = 184;

  typedef enum logic [2:0] {
    VERDICT_NONE     = 3'd0,
    VERDICT_GOOD_REC = 3'd1,
    VERDICT_GOOD_OTH = 3'd2,
    VERDICT_CRC_BAD  = 3'd3,
    VERDICT_OVERFLOW = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [31:0] sync_pattern;
    logic [15:0] record_type;
    logic [15:0] idle_timeout;
  } sfpr_cfg_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [8:0]  payload_index;
    logic        payload_valid;
    logic        frame_end;
    verdict_e    verdict;
    logic        timed_out;
    logic [15:0] frame_length;
    logic [15:0] frame_type;
    logic [31:0] good_count;
    logic [31:0] error_count;
    logic [31:0] timeout_count;
    logic [31:0] byte_count;
  } sfpr_result_t;

endpackage

@@ src/sync_framed_packet_receiver_crc32_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_crc32_unit
// Sync-framed packet receiver with running CRC-32 over the payload.
//
//   channel   dir  tdata                         tuser          tlast
//   s_axis    in   rx_byte                       opcode         -
//   m_axis    out  payload, index, verdict, ...  payload_valid  frame_end
//   cfg       in   write enable, index, data     -              -
//
// one word per cycle; each accepted word yields one result word in the next cycle,
// computed by the parser and crc step and held in the result register
// s_axis_tready is low only while a result waits and m_axis_tready is low
// reset clears all frame state, counters and config (idle timeout to 250)
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver_crc32_unit #(
  parameter int unsigned PAYLOAD_BYTES = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // rx_byte
  input  logic                            s_axis_tuser,   // opcode
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // payload_byte, payload_index, verdict, timed_out, frame_length, frame_type,
  // good_count, error_count, timeout_count, byte_count, zero pad
  output logic [sfpr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tuser,   // payload_valid
  output logic                            m_axis_tlast,   // frame_end
  input  logic                            cfg_we_i,
  input  logic [sfpr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sfpr_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import sfpr_pkg::*;

  sfpr_cfg_t    cfg_q;
  sfpr_result_t res_d, res_q;
  logic         space, fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_pattern <= '0;
      cfg_q.record_type  <= '0;
      cfg_q.idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SYNC_PATTERN: cfg_q.sync_pattern <= cfg_data_i;
        CFG_RECORD_TYPE:  cfg_q.record_type  <= cfg_data_i[15:0];
        CFG_IDLE_TIMEOUT: cfg_q.idle_timeout <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = space;
  assign fire          = s_axis_tvalid && space;

  sfpr_parser #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .fire_i    (fire),
    .opcode_i  (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .result_o  (res_d)
  );

  sfpr_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (fire),
    .result_i (res_d),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .space_o  (space),
    .result_o (res_q)
  );

  assign m_axis_tdata = {3'b000, res_q.byte_count, res_q.timeout_count,
                         res_q.error_count, res_q.good_count, res_q.frame_type,
                         res_q.frame_length, res_q.timed_out, res_q.verdict,
                         res_q.payload_index, res_q.payload_byte};
  assign m_axis_tuser = res_q.payload_valid;
  assign m_axis_tlast = res_q.frame_end;

  a_end_has_verdict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (res_q.verdict != VERDICT_NONE)))
    else $error("frame end and verdict disagree");

  a_overflow_no_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.verdict == VERDICT_OVERFLOW) |-> !m_axis_tuser)
    else $error("overflow word carries a payload byte");

  a_tick_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && s_axis_tuser == OP_TICK) |=>
      (m_axis_tvalid && !m_axis_tlast && !m_axis_tuser && !res_q.timed_out))
    else $error("tick produced a flagged result");

endmodule

@@ src/sfpr_crc32.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_crc32
// One-byte step of an MSB-first CRC-32, no reflection.
// ----------------------------------------------------------------------------
module sfpr_crc32 (
  input  logic [31:0] crc_i,
  input  logic [7:0]  data_i,
  output logic [31:0] crc_o
);
  import sfpr_pkg::*;

  logic [31:0] c;

  always_comb begin
    c = {crc_i[31:24] ^ data_i, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    crc_o = {crc_i[23:0], 8'h00} ^ c;
  end

endmodule

@@ src/sfpr_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_parser
// Frame state machine, field assembly, idle timer and counters; builds the
// result of each accepted word.
// ----------------------------------------------------------------------------
module sfpr_parser #(
  parameter int unsigned PAYLOAD_BYTES = 512
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfpr_pkg::sfpr_cfg_t    cfg_i,
  input  logic                   fire_i,
  input  logic                   opcode_i,
  input  logic [7:0]             rx_byte_i,
  output sfpr_pkg::sfpr_result_t result_o
);
  import sfpr_pkg::*;

  localparam int unsigned POS_W = $clog2(PAYLOAD_BYTES + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(PAYLOAD_BYTES);

  typedef enum logic [2:0] {
    PH_SYNC0   = 3'd0,
    PH_SYNC1   = 3'd1,
    PH_SYNC2   = 3'd2,
    PH_SYNC3   = 3'd3,
    PH_LENGTH  = 3'd4,
    PH_TYPE    = 3'd5,
    PH_CRC     = 3'd6,
    PH_PAYLOAD = 3'd7
  } phase_e;

  phase_e      phase_q, phase_d, phase_eff;
  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [15:0] len_q, len_d;
  logic [15:0] type_q, type_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] crc_q, crc_d, crc_next;
  logic [15:0] idle_q, idle_d;
  logic [31:0] good_q, good_d;
  logic [31:0] err_q, err_d;
  logic [31:0] tout_q, tout_d;
  logic [31:0] bytes_q, bytes_d;
  logic [7:0]  sync_want;
  logic [15:0] pos_ext, pos_inc_ext;
  logic        timeout;

  sfpr_crc32 u_crc (
    .crc_i  (crc_q),
    .data_i (rx_byte_i),
    .crc_o  (crc_next)
  );

  assign pos_inc     = pos_q + 1'b1;
  assign pos_ext     = 16'(pos_q);
  assign pos_inc_ext = 16'(pos_inc);
  assign timeout     = (phase_q != PH_SYNC0) && (idle_q > cfg_i.idle_timeout);
  assign phase_eff   = timeout ? PH_SYNC0 : phase_q;
  assign sync_want   = cfg_i.sync_pattern[{phase_eff[1:0], 3'b000} +: 8];

  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    type_d  = type_q;
    exp_d   = exp_q;
    crc_d   = crc_q;
    idle_d  = idle_q;
    good_d  = good_q;
    err_d   = err_q;
    tout_d  = tout_q;
    bytes_d = bytes_q;

    result_o               = '0;
    result_o.verdict       = VERDICT_NONE;

    if (fire_i) begin
      if (opcode_i == OP_TICK) begin
        if (idle_q != IDLE_MAX) begin
          idle_d = idle_q + 16'd1;
        end
      end else begin
        bytes_d = bytes_q + 32'd1;
        idle_d  = '0;
        if (timeout) begin
          tout_d             = tout_q + 32'd1;
          result_o.timed_out = 1'b1;
        end
        unique case (phase_eff)
          PH_SYNC0, PH_SYNC1, PH_SYNC2, PH_SYNC3: begin
            if (rx_byte_i == sync_want) begin
              unique case (phase_eff)
                PH_SYNC0: phase_d = PH_SYNC1;
                PH_SYNC1: phase_d = PH_SYNC2;
                PH_SYNC2: phase_d = PH_SYNC3;
                default: begin
                  phase_d = PH_LENGTH;
                  pos_d   = '0;
                  len_d   = '0;
                end
              endcase
            end else begin
              phase_d = PH_SYNC0;
            end
          end
          PH_LENGTH: begin
            len_d = {rx_byte_i, len_q[15:8]};
            if (pos_ext == 16'd1) begin
              phase_d = PH_TYPE;
              pos_d   = '0;
              type_d  = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          PH_TYPE: begin
            type_d = {rx_byte_i, type_q[15:8]};
            if (pos_ext == 16'd1) begin
              phase_d = PH_CRC;
              pos_d   = '0;
              exp_d   = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          PH_CRC: begin
            exp_d = {rx_byte_i, exp_q[31:8]};
            if (pos_ext == 16'd3) begin
              phase_d = PH_PAYLOAD;
              pos_d   = '0;
              crc_d   = '0;
            end else begin
              pos_d = pos_inc;
            end
          end
          default: begin
            if (pos_q < POS_LIMIT) begin
              result_o.payload_byte  = rx_byte_i;
              result_o.payload_index = pos_ext[8:0];
              result_o.payload_valid = 1'b1;
              pos_d                  = pos_inc;
              crc_d                  = crc_next;
              if (pos_inc_ext == len_q) begin
                result_o.frame_end = 1'b1;
                phase_d            = PH_SYNC0;
                if (crc_next == exp_q) begin
                  result_o.verdict = (type_q == cfg_i.record_type) ?
                                     VERDICT_GOOD_REC : VERDICT_GOOD_OTH;
                  good_d           = good_q + 32'd1;
                end else begin
                  result_o.verdict = VERDICT_CRC_BAD;
                  err_d            = err_q + 32'd1;
                end
              end
            end else begin
              result_o.frame_end = 1'b1;
              result_o.verdict   = VERDICT_OVERFLOW;
              err_d              = err_q + 32'd1;
              phase_d            = PH_SYNC0;
            end
          end
        endcase
      end
    end

    result_o.frame_length  = len_d;
    result_o.frame_type    = type_d;
    result_o.good_count    = good_d;
    result_o.error_count   = err_d;
    result_o.timeout_count = tout_d;
    result_o.byte_count    = bytes_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SYNC0;
      pos_q   <= '0;
      len_q   <= '0;
      type_q  <= '0;
      exp_q   <= '0;
      crc_q   <= '0;
      idle_q  <= '0;
      good_q  <= '0;
      err_q   <= '0;
      tout_q  <= '0;
      bytes_q <= '0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      type_q  <= type_d;
      exp_q   <= exp_d;
      crc_q   <= crc_d;
      idle_q  <= idle_d;
      good_q  <= good_d;
      err_q   <= err_d;
      tout_q  <= tout_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

@@ src/sfpr_out_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpr_out_reg
// Result register with valid/ready; loads while empty or being drained.
// ----------------------------------------------------------------------------
module sfpr_out_reg (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  sfpr_pkg::sfpr_result_t result_i,
  input  logic                   ready_i,
  output logic                   valid_o,
  output logic                   space_o,
  output sfpr_pkg::sfpr_result_t result_o
);
  import sfpr_pkg::*;

  logic         valid_q, valid_d;
  sfpr_result_t data_q;

  assign space_o = !valid_q || ready_i;
  assign valid_d = load_i || (valid_q && !ready_i);
  assign valid_o = valid_q;
  assign result_o = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

endmodule

@@ bench/sync_framed_packet_receiver_crc32_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_framed_packet_receiver_crc32_unit_tb
// Self-checking bench for the sync-framed packet receiver with CRC-32.
//
// Serial bytes and millisecond ticks go in on the slave stream. A frame parser
// kept in the bench works out the result word for every accepted input word:
// payload byte and index, frame verdict, idle timeout flag, the length and type
// shift registers and the four running counters. Each result word is checked
// field by field against the oldest prediction. Directed tests cover the
// verdicts, sync handling, idle timeout at and just above the limit and the
// payload buffer limit; a random phase then sends well-formed frames with
// random content mixed with noise, ticks and broken frames under several
// register settings. The sender pauses in random bursts and the receiver
// stalls on its own pattern.
// ----------------------------------------------------------------------------
module sync_framed_packet_receiver_crc32_unit_tb;
  import sfpr_pkg::*;

  localparam int unsigned PAYLOAD_BYTES = 512;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [2:0] PH_SYNC0 = 3'd0;
  localparam logic [2:0] PH_SYNC3 = 3'd3;
  localparam logic [2:0] PH_LEN = 3'd4;
  localparam logic [2:0] PH_TYPE = 3'd5;
  localparam logic [2:0] PH_CRC = 3'd6;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic m_axis_tlast;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  sync_framed_packet_receiver_crc32_unit #(
    .PAYLOAD_BYTES(PAYLOAD_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // parser copy: registers and frame state
  logic [31:0] cfg_sync = '0;
  logic [15:0] cfg_rtype = '0;
  logic [15:0] cfg_tmo = IDLE_TIMEOUT_RST;
  logic [2:0] phase = PH_SYNC0;
  int unsigned fpos = 0;
  logic [15:0] len_sh = '0;
  logic [15:0] type_sh = '0;
  logic [31:0] crc_want = '0;
  logic [31:0] crc_run = '0;
  logic [15:0] idle_ticks = '0;
  logic [31:0] good_tot = '0;
  logic [31:0] err_tot = '0;
  logic [31:0] tmo_tot = '0;
  logic [31:0] byte_tot = '0;

  sfpr_result_t frame_reports_q[$];
  int unsigned words_sent = 0;
  int unsigned burst_left = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;

  function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {b, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic sfpr_result_t parse_rx_word(input logic op, input logic [7:0] b);
    sfpr_result_t r;
    r = '0;
    r.verdict = VERDICT_NONE;
    if (op == OP_TICK) begin
      if (idle_ticks != IDLE_MAX) idle_ticks++;
    end else begin
      byte_tot++;
      if (phase != PH_SYNC0 && idle_ticks > cfg_tmo) begin
        tmo_tot++;
        phase = PH_SYNC0;
        r.timed_out = 1'b1;
      end
      idle_ticks = '0;
      if (phase <= PH_SYNC3) begin
        if (b == cfg_sync[8*phase +: 8]) begin
          phase = phase + 3'd1;
          if (phase == PH_LEN) begin
            fpos = 0;
            len_sh = '0;
          end
        end else begin
          phase = PH_SYNC0;
        end
      end else if (phase == PH_LEN) begin
        len_sh = {b, len_sh[15:8]};
        if (fpos == 1) begin
          phase = PH_TYPE;
          fpos = 0;
          type_sh = '0;
        end else begin
          fpos++;
        end
      end else if (phase == PH_TYPE) begin
        type_sh = {b, type_sh[15:8]};
        if (fpos == 1) begin
          phase = PH_CRC;
          fpos = 0;
          crc_want = '0;
        end else begin
          fpos++;
        end
      end else if (phase == PH_CRC) begin
        crc_want = {b, crc_want[31:8]};
        if (fpos == 3) begin
          phase = phase + 3'd1;
          fpos = 0;
          crc_run = '0;
        end else begin
          fpos++;
        end
      end else if (fpos < PAYLOAD_BYTES) begin
        r.payload_byte = b;
        r.payload_index = fpos[8:0];
        r.payload_valid = 1'b1;
        fpos++;
        crc_run = crc32_step(crc_run, b);
        if (fpos == 32'(len_sh)) begin
          r.frame_end = 1'b1;
          if (crc_run == crc_want) begin
            r.verdict = (type_sh == cfg_rtype) ? VERDICT_GOOD_REC : VERDICT_GOOD_OTH;
            good_tot++;
          end else begin
            r.verdict = VERDICT_CRC_BAD;
            err_tot++;
          end
          phase = PH_SYNC0;
        end
      end else begin
        r.frame_end = 1'b1;
        r.verdict = VERDICT_OVERFLOW;
        err_tot++;
        phase = PH_SYNC0;
      end
    end
    r.frame_length = len_sh;
    r.frame_type = type_sh;
    r.good_count = good_tot;
    r.error_count = err_tot;
    r.timeout_count = tmo_tot;
    r.byte_count = byte_tot;
    return r;
  endfunction

  task automatic send_word(input logic op, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    frame_reports_q.push_back(parse_rx_word(op, b));
    words_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(OP_TICK, 8'($urandom));
  endtask

  // cut < 0 sends the whole frame; flip_at >= 0 corrupts one header or payload word
  task automatic send_frame(input logic [15:0] flen, input logic [15:0] ftype,
                            input int nbytes, input bit bad_crc, input int cut,
                            input int flip_at, input int unsigned tick_max);
    logic [7:0] pl[$];
    logic [7:0] words[$];
    logic [31:0] crc;
    int n;
    crc = '0;
    for (int i = 0; i < nbytes; i++) begin
      pl.push_back(8'($urandom));
      crc = crc32_step(crc, pl[i]);
    end
    if (bad_crc) crc ^= 32'h1 << $urandom_range(0, 31);
    for (int k = 0; k < 4; k++) words.push_back(cfg_sync[8*k +: 8]);
    words.push_back(flen[7:0]);
    words.push_back(flen[15:8]);
    words.push_back(ftype[7:0]);
    words.push_back(ftype[15:8]);
    for (int k = 0; k < 4; k++) words.push_back(crc[8*k +: 8]);
    foreach (pl[i]) words.push_back(pl[i]);
    if (flip_at >= 0 && flip_at < words.size())
      words[flip_at] ^= 8'($urandom_range(1, 255));
    n = (cut < 0 || cut > words.size()) ? words.size() : cut;
    for (int i = 0; i < n; i++) begin
      if (i > 0 && tick_max > 0 && $urandom_range(0, 7) == 0)
        send_ticks($urandom_range(1, tick_max));
      send_word(OP_BYTE, words[i]);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (frame_reports_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SYNC_PATTERN: cfg_sync = val;
      CFG_RECORD_TYPE: cfg_rtype = val[15:0];
      CFG_IDLE_TIMEOUT: cfg_tmo = val[15:0];
      default: ;
    endcase
  endtask

  function automatic logic [15:0] tick_room();
    return (cfg_tmo > 16'd20) ? 16'd20 : cfg_tmo;
  endfunction

  // reset values: sync pattern of zeros, record type 0, timeout 250
  task automatic test_reset_verdicts();
    send_ticks(2);
    send_frame(16'd1, 16'h0000, 1, 1'b0, -1, -1, 0);
    send_frame(16'd2, 16'h1234, 2, 1'b0, -1, -1, 0);
    send_frame(16'd1, 16'h0000, 1, 1'b1, -1, -1, 0);
  endtask

  task automatic test_sync_handling();
    write_reg(CFG_SYNC_PATTERN, 32'hA5C3_5A3C);
    write_reg(CFG_RECORD_TYPE, 32'h0000_BEEF);
    // mismatch on the third sync word, and that word is the first sync word
    send_word(OP_BYTE, 8'h3C);
    send_word(OP_BYTE, 8'h5A);
    send_word(OP_BYTE, 8'h3C);
    send_frame(16'd3, 16'hBEEF, 3, 1'b0, -1, -1, 0);
    write_reg(CFG_SYNC_PATTERN, 32'hFFFF_FFFF);
    write_reg(CFG_RECORD_TYPE, 32'h0000_FFFF);
    send_frame(16'd1, 16'hFFFF, 1, 1'b0, -1, -1, 0);
  endtask

  task automatic test_idle_timeout();
    write_reg(CFG_SYNC_PATTERN, 32'h0102_0304);
    write_reg(CFG_IDLE_TIMEOUT, 32'd0);
    send_frame(16'd2, 16'h0007, 2, 1'b0, 2, -1, 0);
    send_ticks(1);
    // timed-out word restarts as the first sync word
    send_frame(16'd2, 16'h0007, 2, 1'b0, -1, -1, 0);
    write_reg(CFG_IDLE_TIMEOUT, 32'd20);
    send_frame(16'd4, 16'h0000, 4, 1'b0, 6, -1, 0);
    // a gap equal to the timeout keeps the frame
    send_ticks(20);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    // one tick more drops it
    send_ticks(21);
    send_frame(16'd1, 16'h0000, 1, 1'b0, -1, -1, 0);
    write_reg(CFG_IDLE_TIMEOUT, {16'h0, IDLE_TIMEOUT_RST});
    send_frame(16'd1, 16'h0000, 1, 1'b0, -1, -1, 0);
  endtask

  task automatic test_payload_limit();
    write_reg(CFG_RECORD_TYPE, 32'h0000_0042);
    send_frame(16'd512, 16'h0042, 512, 1'b0, -1, -1, 0);
    send_frame(16'd0, 16'h0042, 513, 1'b0, -1, -1, 0);
  endtask

  task automatic test_random_traffic();
    int unsigned target;
    int unsigned pick;
    int unsigned flen;
    logic [15:0] ftype;
    for (int round = 0; round < 6; round++) begin
      case (round)
        0: begin
          write_reg(CFG_SYNC_PATTERN, 32'hFFFF_FFFF);
          write_reg(CFG_RECORD_TYPE, 32'h0000_FFFF);
          write_reg(CFG_IDLE_TIMEOUT, 32'd0);
        end
        1: begin
          write_reg(CFG_SYNC_PATTERN, 32'h0000_0000);
          write_reg(CFG_RECORD_TYPE, 32'h0000_0000);
          write_reg(CFG_IDLE_TIMEOUT, 32'h0000_FFFF);
        end
        2: begin
          write_reg(CFG_SYNC_PATTERN, $urandom);
          write_reg(CFG_IDLE_TIMEOUT, {16'h0, IDLE_TIMEOUT_RST});
          write_reg(CFG_UNUSED, $urandom);
        end
        default: begin
          write_reg(CFG_SYNC_PATTERN, $urandom);
          write_reg(CFG_RECORD_TYPE, $urandom);
          write_reg(CFG_IDLE_TIMEOUT, $urandom_range(1, 40));
        end
      endcase
      target = words_sent + 110;
      while (words_sent < target) begin
        pick = $urandom_range(0, 99);
        flen = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 512) : $urandom_range(1, 24);
        ftype = $urandom_range(0, 1) ? cfg_rtype : 16'($urandom);
        if (pick < 55) begin
          send_frame(16'(flen), ftype, flen, $urandom_range(0, 4) == 0, -1, -1, tick_room());
        end else if (pick < 70) begin
          repeat ($urandom_range(1, 8))
            send_word(OP_BYTE, $urandom_range(0, 1) ? cfg_sync[8*$urandom_range(0, 3) +: 8]
                                                    : 8'($urandom));
        end else if (pick < 80) begin
          send_ticks($urandom_range(1, (cfg_tmo < 64) ? cfg_tmo + 3 : 30));
        end else begin
          send_frame(16'(flen), ftype, flen, 1'b0, $urandom_range(1, 12 + flen),
                     $urandom_range(0, 1) ? int'($urandom_range(0, 11)) : -1, tick_room());
          if (cfg_tmo < 64) send_ticks(cfg_tmo + 1);
        end
      end
    end
  endtask

  // receiver stall pattern
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_cnt = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 200);
    end else begin
      stall_left--;
    end
    stall_cnt++;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= (stall_cnt % 4) != 3;
      default: m_axis_tready <= (stall_cnt % 9) > 5;
    endcase
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    sfpr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frame_reports_q.size() == 0) begin
        $display("%0t: result word with none expected, actual %0h", $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = frame_reports_q.pop_front();
        check_field("payload_byte", 32'(want.payload_byte), 32'(m_axis_tdata[7:0]));
        check_field("payload_index", 32'(want.payload_index), 32'(m_axis_tdata[16:8]));
        check_field("payload_valid", 32'(want.payload_valid), 32'(m_axis_tuser));
        check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
        check_field("verdict", 32'(want.verdict), 32'(m_axis_tdata[19:17]));
        check_field("timed_out", 32'(want.timed_out), 32'(m_axis_tdata[20]));
        check_field("frame_length", 32'(want.frame_length), 32'(m_axis_tdata[36:21]));
        check_field("frame_type", 32'(want.frame_type), 32'(m_axis_tdata[52:37]));
        check_field("good_count", want.good_count, m_axis_tdata[84:53]);
        check_field("error_count", want.error_count, m_axis_tdata[116:85]);
        check_field("timeout_count", want.timeout_count, m_axis_tdata[148:117]);
        check_field("byte_count", want.byte_count, m_axis_tdata[180:149]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("sync_framed_packet_receiver_crc32_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_verdicts();
    test_sync_handling();
    test_idle_timeout();
    test_payload_limit();
    test_random_traffic();
    drain_results();
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sync_framed_packet_receiver_crc32_unit test passed");
    end else begin
      $display("sync_framed_packet_receiver_crc32_unit test failed");
    end
    $finish;
  end

endmodule
